>>> hw/rtl/swthd_pkg.sv
// shared types and constants for the single-wire temperature and humidity decoder
package swthd_pkg;

    // frame geometry
    localparam int FRAME_BITS = 40;
    localparam int CNT_W      = 6;
    localparam int US_W       = 16;
    localparam int WORD_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;

    // request kinds on the input channel
    localparam logic REQ_START    = 1'b0;
    localparam logic REQ_INTERVAL = 1'b1;

    // register reset values
    localparam logic [US_W-1:0] SYNC_MIN_RST = 16'd140;
    localparam logic [US_W-1:0] SYNC_MAX_RST = 16'd180;
    localparam logic [US_W-1:0] ZERO_MIN_RST = 16'd60;
    localparam logic [US_W-1:0] ZERO_MAX_RST = 16'd90;
    localparam logic [US_W-1:0] ONE_MIN_RST  = 16'd100;
    localparam logic [US_W-1:0] ONE_MAX_RST  = 16'd135;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_MIN = 3'd0,
        CFG_SYNC_MAX = 3'd1,
        CFG_ZERO_MIN = 3'd2,
        CFG_ZERO_MAX = 3'd3,
        CFG_ONE_MIN  = 3'd4,
        CFG_ONE_MAX  = 3'd5
    } cfg_idx_t;

    // pulse width windows, all bounds exclusive
    typedef struct packed {
        logic [US_W-1:0] sync_min;
        logic [US_W-1:0] sync_max;
        logic [US_W-1:0] zero_min;
        logic [US_W-1:0] zero_max;
        logic [US_W-1:0] one_min;
        logic [US_W-1:0] one_max;
    } win_cfg_t;

    // one decoded frame result
    typedef struct packed {
        logic              emit;
        logic [WORD_W-1:0] humidity;
        logic [WORD_W-1:0] temperature;
        logic              checksum_ok;
    } frame_res_t;

    // strict window test
    function automatic logic in_window(input logic [US_W-1:0] v,
                                       input logic [US_W-1:0] lo,
                                       input logic [US_W-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

endpackage

>>> hw/rtl/swthd_frame.sv
// frame capture state, interval classification and checksum check
module swthd_frame (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      fire,
    input  logic                      req_type,
    input  logic [swthd_pkg::US_W-1:0] interval_us,
    input  swthd_pkg::win_cfg_t       win_cfg,
    output swthd_pkg::frame_res_t     res
);
    import swthd_pkg::*;

    logic [CNT_W-1:0]      bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic                  capturing_reg, capturing_next;
    logic [WORD_W-1:0]     humidity_reg, humidity_next;
    logic [WORD_W-1:0]     temperature_reg, temperature_next;

    logic                  is_sync, is_zero, is_one;
    logic [CNT_W-1:0]      bit_idx;
    logic [CNT_W-1:0]      count_inc;
    logic [FRAME_BITS-1:0] frame_set;
    logic [BYTE_W-1:0]     sum;
    logic                  sum_ok;

    // classify the interval
    assign is_sync = in_window(interval_us, win_cfg.sync_min, win_cfg.sync_max);
    assign is_zero = in_window(interval_us, win_cfg.zero_min, win_cfg.zero_max);
    assign is_one  = in_window(interval_us, win_cfg.one_min, win_cfg.one_max);

    // msb first bit placement
    assign bit_idx   = CNT_W'(FRAME_BITS - 1) - bit_count_reg;
    assign count_inc = bit_count_reg + CNT_W'(1);

    always_comb begin
        frame_set = frame_reg;
        if (is_one && !is_zero) begin
            frame_set[bit_idx] = 1'b1;
        end
    end

    // checksum over the updated frame
    assign sum = frame_set[39:32] + frame_set[31:24] + frame_set[23:16] + frame_set[15:8];
    assign sum_ok = (sum == frame_set[7:0]);

    // next state and result
    always_comb begin
        bit_count_next   = bit_count_reg;
        frame_next       = frame_reg;
        capturing_next   = capturing_reg;
        humidity_next    = humidity_reg;
        temperature_next = temperature_reg;
        res.emit         = 1'b0;
        res.checksum_ok  = sum_ok;
        if (fire) begin
            if (req_type == REQ_START) begin
                frame_next     = '0;
                bit_count_next = '0;
                capturing_next = 1'b1;
            end else if (capturing_reg) begin
                if (is_sync) begin
                    bit_count_next = '0;
                end else begin
                    frame_next     = frame_set;
                    bit_count_next = count_inc;
                    if (count_inc == CNT_W'(FRAME_BITS)) begin
                        capturing_next = 1'b0;
                        res.emit       = 1'b1;
                        if (sum_ok) begin
                            humidity_next    = frame_set[39:24];
                            temperature_next = frame_set[23:8];
                        end
                    end
                end
            end
        end
        res.humidity    = humidity_next;
        res.temperature = temperature_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg   <= '0;
            frame_reg       <= '0;
            capturing_reg   <= 1'b0;
            humidity_reg    <= '0;
            temperature_reg <= '0;
        end else begin
            bit_count_reg   <= bit_count_next;
            frame_reg       <= frame_next;
            capturing_reg   <= capturing_next;
            humidity_reg    <= humidity_next;
            temperature_reg <= temperature_next;
        end
    end

endmodule

>>> hw/rtl/single_wire_temp_humidity_decoder_core.sv
// top level of the single-wire temperature and humidity frame decoder
//
//  channel  direction  payload
//  s_       in         tuser: req_type; tdata: interval_us
//  m_       out        tdata: humidity, temperature; tuser: checksum_ok
//  cfg_     in         cfg_index, cfg_data (window bounds)
//
// one item per cycle sustained unless the output register stalls; an item is held
// in the input register, is decoded by the frame logic and its result lands in the
// output register; a result is valid once its last item has passed both registers.
// aresetn is synchronous; it clears the frame state and held words and restores
// the default windows.
// a stalled output register holds the input register, which then drops s_tready.
module single_wire_temp_humidity_decoder_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [15:0] interval_us
    input  logic                           s_tuser,   // [0] req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [15:0] humidity, [31:16] temperature
    output logic                           m_tuser,   // [0] checksum_ok
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [swthd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import swthd_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic              in_req_reg;
    logic [US_W-1:0]   in_iv_reg;
    logic              out_free;
    logic              fire;
    logic              s_accept;
    win_cfg_t          win_reg;
    frame_res_t        res;
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic              m_user_reg;

    // handshake control
    assign out_free      = !m_valid_reg || m_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_tready      = !in_valid_reg || fire;
    assign s_accept      = s_tvalid && s_tready;
    assign in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign cfg_ready     = 1'b1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_accept) begin
            in_req_reg <= s_tuser;
            in_iv_reg  <= s_tdata;
        end
    end

    // window registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.sync_min <= SYNC_MIN_RST;
            win_reg.sync_max <= SYNC_MAX_RST;
            win_reg.zero_min <= ZERO_MIN_RST;
            win_reg.zero_max <= ZERO_MAX_RST;
            win_reg.one_min  <= ONE_MIN_RST;
            win_reg.one_max  <= ONE_MAX_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SYNC_MIN: win_reg.sync_min <= cfg_data;
                CFG_SYNC_MAX: win_reg.sync_max <= cfg_data;
                CFG_ZERO_MIN: win_reg.zero_min <= cfg_data;
                CFG_ZERO_MAX: win_reg.zero_max <= cfg_data;
                CFG_ONE_MIN:  win_reg.one_min  <= cfg_data;
                CFG_ONE_MAX:  win_reg.one_max  <= cfg_data;
                default: ;
            endcase
        end
    end

    // frame decode
    swthd_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .req_type    (in_req_reg),
        .interval_us (in_iv_reg),
        .win_cfg     (win_reg),
        .res         (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && res.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (fire && res.emit) begin
            m_data_reg <= {res.temperature, res.humidity};
            m_user_reg <= res.checksum_ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> tb/tb_single_wire_temp_humidity_decoder_core.sv
// self-checking testbench for the single-wire temperature and humidity frame decoder
`timescale 1ns / 1ps

module tb_single_wire_temp_humidity_decoder_core;
    import swthd_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TAIL_CYCLES = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 40;

    // register indexes past the last window bound, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 3'd7;

    // one input item as queued for the driver
    typedef struct {
        logic            req;
        logic [US_W-1:0] iv;
    } pulse_t;

    // one decoded frame as it should leave the block
    typedef struct {
        logic [WORD_W-1:0] humidity;
        logic [WORD_W-1:0] temperature;
        logic              crc_ok;
    } frame_rec_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic                 s_tuser   = REQ_START;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    // decoder mirror: windows, shift register and held words
    win_cfg_t          win = '{sync_min: SYNC_MIN_RST, sync_max: SYNC_MAX_RST,
                               zero_min: ZERO_MIN_RST, zero_max: ZERO_MAX_RST,
                               one_min: ONE_MIN_RST, one_max: ONE_MAX_RST};
    logic [CNT_W-1:0]  bits_rx = '0;
    logic [FRAME_BITS-1:0] shreg = '0;
    logic              armed   = 1'b0;
    logic [WORD_W-1:0] hum_held = '0;
    logic [WORD_W-1:0] tmp_held = '0;

    pulse_t     pulse_q[$];
    frame_rec_t frames_due[$];
    pulse_t     next_pulse;
    frame_rec_t due_rec;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_cnt = 0;
    int items_taken = 0;
    int frames_seen = 0;
    int frames_good = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    logic hold_kick = 1'b0;

    single_wire_temp_humidity_decoder_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic flag_error(input string msg);
        if (mismatch_cnt < MAX_PRINTS) $display("error at cycle %0d: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    // advance the frame decoder by one accepted item
    task automatic decode_item(input logic req, input logic [US_W-1:0] iv);
        logic [BYTE_W-1:0] sum;
        frame_rec_t rec;
        if (req == REQ_START) begin
            shreg   = '0;
            bits_rx = '0;
            armed   = 1'b1;
        end else if (armed) begin
            if (iv > win.sync_min && iv < win.sync_max) begin
                bits_rx = '0;
            end else begin
                // zero window takes priority over the one window
                if (!(iv > win.zero_min && iv < win.zero_max) &&
                    (iv > win.one_min && iv < win.one_max) && bits_rx < FRAME_BITS)
                    shreg[FRAME_BITS-1-bits_rx] = 1'b1;
                bits_rx = bits_rx + 1'b1;
                if (bits_rx == FRAME_BITS) begin
                    armed = 1'b0;
                    sum = shreg[39:32] + shreg[31:24] + shreg[23:16] + shreg[15:8];
                    rec.crc_ok = (sum == shreg[7:0]);
                    if (rec.crc_ok) begin
                        hum_held = shreg[39:24];
                        tmp_held = shreg[23:8];
                    end
                    rec.humidity    = hum_held;
                    rec.temperature = tmp_held;
                    frames_due.push_back(rec);
                end
            end
        end
    endtask

    // register write as seen by the decoder mirror
    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        case (idx)
            CFG_SYNC_MIN: win.sync_min = val;
            CFG_SYNC_MAX: win.sync_max = val;
            CFG_ZERO_MIN: win.zero_min = val;
            CFG_ZERO_MAX: win.zero_max = val;
            CFG_ONE_MIN:  win.one_min  = val;
            CFG_ONE_MAX:  win.one_max  = val;
            default: ;
        endcase
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_cfg(idx, val);
    endtask

    task automatic set_windows(input logic [15:0] smin, input logic [15:0] smax,
                               input logic [15:0] zmin, input logic [15:0] zmax,
                               input logic [15:0] omin, input logic [15:0] omax);
        cfg_write(CFG_SYNC_MIN, smin);
        cfg_write(CFG_SYNC_MAX, smax);
        cfg_write(CFG_ZERO_MIN, zmin);
        cfg_write(CFG_ZERO_MAX, zmax);
        cfg_write(CFG_ONE_MIN, omin);
        cfg_write(CFG_ONE_MAX, omax);
    endtask

    // random width strictly inside a window, anything when the window is empty
    function automatic logic [15:0] pick_in(input logic [15:0] lo, input logic [15:0] hi);
        if (int'(hi) > int'(lo) + 1)
            return 16'($urandom_range(int'(lo) + 1, int'(hi) - 1));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] pulse_width(input logic one);
        if (one) return pick_in(win.one_min, win.one_max);
        if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
        return pick_in(win.zero_min, win.zero_max);
    endfunction

    task automatic queue_item(input logic req, input logic [15:0] iv);
        pulse_t p;
        p.req = req;
        p.iv  = iv;
        pulse_q.push_back(p);
    endtask

    task automatic queue_start();
        queue_item(REQ_START, 16'($urandom_range(0, 65535)));
    endtask

    task automatic queue_bits(input logic [FRAME_BITS-1:0] data, input int count);
        for (int i = FRAME_BITS - 1; i >= FRAME_BITS - count; i--)
            queue_item(REQ_INTERVAL, pulse_width(data[i]));
    endtask

    // one sensor transaction: mostly well formed, some broken or pure noise
    task automatic queue_frame();
        int kind;
        logic [31:0] body;
        logic [7:0] ck;
        kind = $urandom_range(0, 99);
        body = $urandom();
        ck = body[31:24] + body[23:16] + body[15:8] + body[7:0];
        if (kind >= 70 && kind < 80) ck = ck ^ 8'($urandom_range(1, 255));
        // stray edges, ignored unless a capture is still open
        repeat ($urandom_range(0, 2)) queue_item(REQ_INTERVAL, 16'($urandom_range(0, 65535)));
        queue_start();
        if (kind < 80) begin
            if ($urandom_range(0, 1)) queue_item(REQ_INTERVAL, pick_in(win.sync_min, win.sync_max));
            queue_bits({body, ck}, FRAME_BITS);
        end else if (kind < 90) begin
            // partial frame, then a restart or a sync, then a full frame
            queue_bits({$urandom(), 8'($urandom())}, $urandom_range(1, FRAME_BITS - 1));
            if ($urandom_range(0, 1)) queue_start();
            else queue_item(REQ_INTERVAL, pick_in(win.sync_min, win.sync_max));
            queue_bits({body, ck}, FRAME_BITS);
        end else begin
            repeat (FRAME_BITS + 2) begin
                if ($urandom_range(0, 1)) queue_item(REQ_INTERVAL, 16'($urandom_range(0, 65535)));
                else queue_item(REQ_INTERVAL, pulse_width(1'($urandom_range(0, 1))));
            end
        end
    endtask

    // wait until every item is taken and every frame result has come back
    task automatic settle();
        int waited;
        waited = 0;
        while ((pulse_q.size() != 0 || s_tvalid || frames_due.size() != 0) &&
               waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (frames_due.size() != 0) begin
            flag_error($sformatf("%0d frame results never arrived", frames_due.size()));
            frames_due.delete();
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int frames);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (frames) queue_frame();
        settle();
    endtask

    // driver: offers queued items, feeds the decoder mirror on each accept
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_item(s_tuser, s_tdata);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pulse_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_pulse = pulse_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_pulse.req;
                    s_tdata  <= next_pulse.iv;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge aclk) begin
        if (hold_kick) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // monitor: checks each frame result against the oldest one due
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                frames_seen++;
                if (frames_due.size() == 0) begin
                    flag_error($sformatf("frame result with none due, tdata %h", m_tdata));
                end else begin
                    due_rec = frames_due.pop_front();
                    if (due_rec.crc_ok) frames_good++;
                    if (m_tdata[15:0] != due_rec.humidity)
                        flag_error($sformatf("humidity %h, want %h",
                                             m_tdata[15:0], due_rec.humidity));
                    if (m_tdata[31:16] != due_rec.temperature)
                        flag_error($sformatf("temperature %h, want %h",
                                             m_tdata[31:16], due_rec.temperature));
                    if (m_tuser != due_rec.crc_ok)
                        flag_error($sformatf("checksum_ok %b, want %b",
                                             m_tuser, due_rec.crc_ok));
                end
            end
            m_tready <= (hold_left == 0) && !hold_kick &&
                        ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // boundaries of the reset windows, idle edges, sync and restart handling
        queue_item(REQ_INTERVAL, 16'd120);
        queue_item(REQ_INTERVAL, 16'd65535);
        queue_start();
        queue_item(REQ_INTERVAL, 16'd160);
        queue_item(REQ_INTERVAL, 16'd0);
        queue_item(REQ_INTERVAL, 16'd65535);
        queue_item(REQ_INTERVAL, 16'd140);
        queue_item(REQ_INTERVAL, 16'd180);
        queue_item(REQ_INTERVAL, 16'd60);
        queue_item(REQ_INTERVAL, 16'd90);
        queue_item(REQ_INTERVAL, 16'd100);
        queue_item(REQ_INTERVAL, 16'd135);
        queue_item(REQ_INTERVAL, 16'd61);
        queue_item(REQ_INTERVAL, 16'd89);
        queue_item(REQ_INTERVAL, 16'd101);
        queue_item(REQ_INTERVAL, 16'd134);
        queue_item(REQ_INTERVAL, 16'd141);
        queue_item(REQ_INTERVAL, 16'd179);
        queue_start();
        queue_start();

        // reset windows, full rate, receiver held off so the input backs up
        hold_kick <= 1'b1;
        @(posedge aclk);
        hold_kick <= 1'b0;
        run_phase(0, 0, 8);

        // tiny sync window, wide zero and one windows overlapping at 1000
        set_windows(16'd0, 16'd3, 16'd3, 16'd1001, 16'd999, 16'd65535);
        run_phase(57, 0, 8);

        // sync near the top, one and zero windows overlapping at the bottom
        set_windows(16'd65000, 16'd65535, 16'd0, 16'd2, 16'd0, 16'd3);
        run_phase(0, 57, 8);

        // sync window overlapping the zero window
        set_windows(16'd50, 16'd70, 16'd60, 16'd90, 16'd100, 16'd135);
        run_phase(18, 18, 8);

        // every window empty, all widths decode as zero bits
        set_windows(16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0);
        run_phase(0, 0, 6);

        // back to reset windows; writes to unused indexes change nothing
        set_windows(SYNC_MIN_RST, SYNC_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
                    ONE_MIN_RST, ONE_MAX_RST);
        cfg_write(CFG_IDX_SPARE0, 16'h0000);
        cfg_write(CFG_IDX_SPARE1, 16'hffff);
        run_phase(57, 0, 8);

        $display("covered %0d items and %0d frame results, %0d with a good checksum",
                 items_taken, frames_seen, frames_good);
        $display("six window settings incl. empty, full-range and overlapping windows");
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
